@@ rtl/sphv_pkg.sv @@
// sphv_pkg: shared constants for the UV sphere vertex generator.
// Register indexes, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
package sphv_pkg;

  localparam int COUNT_BITS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_CFG_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam logic [CNT_CFG_W-1:0] STACK_COUNT_RST = 10'd16;
  localparam logic [CNT_CFG_W-1:0] SLICE_COUNT_RST = 10'd32;
  localparam logic [CFG_W-1:0]     RADIUS_RST      = 16'd256;

  localparam int POS_W  = 17;
  localparam int NORM_W = 16;
  localparam int UV_W   = 17;
  localparam int ANG_W  = 32;
  localparam int CV_W   = 33;
  localparam int PROD_W = 66;

  localparam int POS_MAX  = 65535;
  localparam int NORM_MAX = 32767;
  localparam int NORM_MIN = -32768;
  localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam int TABLE_LEN = 24;
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

@@ rtl/uv_sphere_vertex_generator_top.sv @@
// UV sphere vertex generator: one vertex (position, normal, UV) per request beat,
// row-major over stacks and slices. Each vertex is worked out by the bit-serial angle
// dividers followed by the iterative CORDIC; a two-entry queue lets request beats be taken
// while a vertex is worked on, and a result beat waits in the output register while the
// next vertex is worked on, which then holds in its output state until the beat is taken.
// Depends on sphv_pkg, sphv_front, sphv_queue, sphv_back.
module uv_sphere_vertex_generator_top import sphv_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output logic [UV_W-1:0]          tex_u,
  output logic [UV_W-1:0]          tex_v,
  output logic                     last_vertex
);

  localparam int QW = 2 * COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [CNT_CFG_W-1:0]  stack_count, slice_count;
  logic [CFG_W-1:0]      sphere_radius;
  logic [COUNT_BITS-1:0] ns, nl;
  logic                  q_can_push, q_push, q_pop, q_valid;
  logic [COUNT_BITS-1:0] f_i, f_j;
  logic                  f_last;
  logic [QW-1:0]         q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= STACK_COUNT_RST;
      slice_count   <= SLICE_COUNT_RST;
      sphere_radius <= RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STACK_COUNT:   stack_count   <= cfg_data[CNT_CFG_W-1:0];
        REG_SLICE_COUNT:   slice_count   <= cfg_data[CNT_CFG_W-1:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (stack_count == '0) begin
      ns = COUNT_BITS'(1);
    end else if (32'(stack_count) > 32'(CNT_MAX)) begin
      ns = CNT_MAX;
    end else begin
      ns = COUNT_BITS'(stack_count);
    end
    if (slice_count == '0) begin
      nl = COUNT_BITS'(1);
    end else if (32'(slice_count) > 32'(CNT_MAX)) begin
      nl = CNT_MAX;
    end else begin
      nl = COUNT_BITS'(slice_count);
    end
  end

  sphv_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .restart, .ns, .nl,
    .q_can_push, .q_push, .q_i(f_i), .q_j(f_j), .q_last(f_last));

  sphv_queue #(.W(QW)) u_queue (
    .clk, .rst, .push(q_push), .din({f_i, f_j, f_last}), .can_push(q_can_push),
    .pop(q_pop), .dout(q_dout), .not_empty(q_valid));

  sphv_back #(.COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid,
    .q_i(q_dout[QW-1:COUNT_BITS+1]), .q_j(q_dout[COUNT_BITS:1]), .q_last(q_dout[0]),
    .q_pop, .ns, .nl, .rad(sphere_radius),
    .out_valid, .out_ready, .pos_x, .pos_y, .pos_z, .norm_x, .norm_y, .norm_z,
    .tex_u, .tex_v, .last_vertex);

endmodule

@@ rtl/sphv_queue.sv @@
// sphv_queue: two-entry queue between the vertex front end and the back end.
// Generic payload width; no package dependencies.
module sphv_queue #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         can_push,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         not_empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign can_push  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/sphv_front.sv @@
// sphv_front: accepts request beats, applies restart and steps the stack and
// slice counters in row-major order. Pushes vertex indexes to the queue.
module sphv_front #(
  parameter int COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  input  logic [COUNT_BITS-1:0] ns,
  input  logic [COUNT_BITS-1:0] nl,
  input  logic                  q_can_push,
  output logic                  q_push,
  output logic [COUNT_BITS-1:0] q_i,
  output logic [COUNT_BITS-1:0] q_j,
  output logic                  q_last
);

  logic [COUNT_BITS-1:0] stack_index;
  logic [COUNT_BITS-1:0] slice_index;
  logic [COUNT_BITS-1:0] stack_index_next;
  logic [COUNT_BITS-1:0] slice_index_next;

  assign in_ready = q_can_push;
  assign q_push   = in_valid && q_can_push;
  assign q_i      = restart ? '0 : stack_index;
  assign q_j      = restart ? '0 : slice_index;
  assign q_last   = (q_i == ns) && (q_j == nl);

  always_comb begin
    if (q_j >= nl) begin
      slice_index_next = '0;
      stack_index_next = (q_i >= ns) ? '0 : q_i + COUNT_BITS'(1);
    end else begin
      slice_index_next = q_j + COUNT_BITS'(1);
      stack_index_next = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_index <= '0;
      slice_index <= '0;
    end else if (q_push) begin
      stack_index <= stack_index_next;
      slice_index <= slice_index_next;
    end
  end

endmodule

@@ rtl/sphv_div.sv @@
// sphv_div: restoring divider, one quotient bit per cycle.
// Keeps the low QW bits of the quotient; no package dependencies.
module sphv_div #(
  parameter int DW = 42,
  parameter int NW = 10,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [NW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          ge;

  assign trial = {rem, dvd[DW-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= ge ? diff[NW-1:0] : trial[NW-1:0];
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

@@ rtl/sphv_cordic.sv @@
// sphv_cordic: iterative rotation-mode CORDIC, one step per cycle.
// Angle in 2^-32 turns, cosine and sine in Q1.30. Uses sphv_pkg.
module sphv_cordic import sphv_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ANG_W-1:0]       turn,
  output logic                   busy,
  output logic signed [CV_W-1:0] cos_o,
  output logic signed [CV_W-1:0] sin_o
);

  localparam int N  = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  localparam int KW = $clog2(TABLE_LEN);

  logic signed [CV_W-1:0] x, y, z, dx, dy, at;
  logic [1:0]             quad;
  logic [KW-1:0]          k;

  assign dx = y >>> k;
  assign dy = x >>> k;
  assign at = signed'({1'b0, ATAN_TURNS[k]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (busy) begin
      k <= k + KW'(1);
      if (k == KW'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= turn[ANG_W-1:ANG_W-2];
      x    <= signed'({1'b0, CORDIC_GAIN});
      y    <= '0;
      z    <= signed'({3'b000, turn[ANG_W-3:0]});
    end else if (busy) begin
      if (!z[CV_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_comb begin
    unique case (quad)
      2'd0: begin cos_o = x;  sin_o = y;  end
      2'd1: begin cos_o = -y; sin_o = x;  end
      2'd2: begin cos_o = -x; sin_o = -y; end
      default: begin cos_o = y; sin_o = -x; end
    endcase
  end

endmodule

@@ rtl/sphv_back.sv @@
// sphv_back: per-vertex arithmetic: angle and UV division, CORDIC, products,
// rounding and clamping, and the result register. Uses sphv_pkg, sphv_div, sphv_cordic.
module sphv_back import sphv_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic [COUNT_BITS-1:0]    q_i,
  input  logic [COUNT_BITS-1:0]    q_j,
  input  logic                     q_last,
  output logic                     q_pop,
  input  logic [COUNT_BITS-1:0]    ns,
  input  logic [COUNT_BITS-1:0]    nl,
  input  logic [CFG_W-1:0]         rad,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output logic [UV_W-1:0]          tex_u,
  output logic [UV_W-1:0]          tex_v,
  output logic                     last_vertex
);

  localparam int PDW = COUNT_BITS + 31;
  localparam int TDW = COUNT_BITS + 32;
  localparam int UDW = COUNT_BITS + 17;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_COR, S_MUL1, S_RND1, S_MUL2, S_RND2, S_OUT
  } state_t;

  state_t state;

  logic [ANG_W-1:0] phi_q, th_q;
  logic [UDW-1:0]   u_q, v_q;
  logic [3:0]       div_busy;
  logic             div_any_busy;
  logic             cor_start;
  logic             cp_busy, ct_busy;
  logic signed [CV_W-1:0] cp, sp, ct, st;

  logic signed [PROD_W-1:0] prod_a, prod_b, prod_c, prod_d;
  logic signed [POS_W-1:0]  ring_radius, ring_height, px, pz;
  logic signed [NORM_W-1:0] nx, ny, nz;
  logic                     vlast;
  logic                     load_out;

  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] v, input int k);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (k - 1);
    return (v + half) >>> k;
  endfunction

  function automatic logic signed [PROD_W-1:0] clip(
    input logic signed [PROD_W-1:0] v, input int lo, input int hi);
    logic signed [PROD_W-1:0] l, h;
    l = PROD_W'(lo);
    h = PROD_W'(hi);
    return (v < l) ? l : ((v > h) ? h : v);
  endfunction

  function automatic logic [UV_W-1:0] uv_clip(input logic [UDW-1:0] q);
    return (q > UDW'(UV_ONE)) ? UV_ONE : UV_W'(q);
  endfunction

  assign q_pop        = (state == S_IDLE) && q_valid;
  assign div_any_busy = |div_busy;
  assign cor_start    = (state == S_DIV) && !div_any_busy;
  assign load_out     = (state == S_OUT) && (!out_valid || out_ready);

  sphv_div #(.DW(PDW), .NW(COUNT_BITS), .QW(ANG_W)) u_div_phi (
    .clk, .rst, .start(q_pop), .dividend({q_i, 31'b0}), .divisor(ns),
    .busy(div_busy[0]), .quotient(phi_q));

  sphv_div #(.DW(TDW), .NW(COUNT_BITS), .QW(ANG_W)) u_div_th (
    .clk, .rst, .start(q_pop), .dividend({q_j, 32'b0}), .divisor(nl),
    .busy(div_busy[1]), .quotient(th_q));

  sphv_div #(.DW(UDW), .NW(COUNT_BITS), .QW(UDW)) u_div_u (
    .clk, .rst, .start(q_pop),
    .dividend({1'b0, q_j, 16'b0} + UDW'(nl >> 1)), .divisor(nl),
    .busy(div_busy[2]), .quotient(u_q));

  sphv_div #(.DW(UDW), .NW(COUNT_BITS), .QW(UDW)) u_div_v (
    .clk, .rst, .start(q_pop),
    .dividend({1'b0, q_i, 16'b0} + UDW'(ns >> 1)), .divisor(ns),
    .busy(div_busy[3]), .quotient(v_q));

  sphv_cordic #(.STEPS(CORDIC_STEPS)) u_cor_phi (
    .clk, .rst, .start(cor_start), .turn(phi_q), .busy(cp_busy),
    .cos_o(cp), .sin_o(sp));

  sphv_cordic #(.STEPS(CORDIC_STEPS)) u_cor_th (
    .clk, .rst, .start(cor_start), .turn(th_q), .busy(ct_busy),
    .cos_o(ct), .sin_o(st));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (q_valid) state <= S_DIV;
        S_DIV:  if (!div_any_busy) state <= S_COR;
        S_COR:  if (!cp_busy && !ct_busy) state <= S_MUL1;
        S_MUL1: state <= S_RND1;
        S_RND1: state <= S_MUL2;
        S_MUL2: state <= S_RND2;
        S_RND2: state <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      vlast <= q_last;
    end
    unique case (state)
      S_MUL1: begin
        prod_a <= signed'({1'b0, rad}) * cp;
        prod_b <= signed'({1'b0, rad}) * sp;
        prod_c <= sp * ct;
        prod_d <= sp * st;
      end
      S_RND1: begin
        ring_height <= POS_W'(clip(rnd_shift(prod_a, 30), -POS_MAX, POS_MAX));
        ring_radius <= POS_W'(clip(rnd_shift(prod_b, 30), -POS_MAX, POS_MAX));
        nx <= NORM_W'(clip(rnd_shift(prod_c, 45), NORM_MIN, NORM_MAX));
        nz <= NORM_W'(clip(rnd_shift(prod_d, 45), NORM_MIN, NORM_MAX));
        ny <= NORM_W'(clip(rnd_shift(PROD_W'(cp), 15), NORM_MIN, NORM_MAX));
      end
      S_MUL2: begin
        prod_a <= ring_radius * ct;
        prod_b <= ring_radius * st;
      end
      S_RND2: begin
        px <= POS_W'(clip(rnd_shift(prod_a, 30), -POS_MAX, POS_MAX));
        pz <= POS_W'(clip(rnd_shift(prod_b, 30), -POS_MAX, POS_MAX));
      end
      default: ;
    endcase
    if (load_out) begin
      pos_x       <= px;
      pos_y       <= ring_height;
      pos_z       <= pz;
      norm_x      <= nx;
      norm_y      <= ny;
      norm_z      <= nz;
      tex_u       <= uv_clip(u_q);
      tex_v       <= uv_clip(v_q);
      last_vertex <= vlast;
    end
  end

  a_last_uv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_vertex) |-> (tex_u == UV_ONE && tex_v == UV_ONE))
    else $error("last vertex without full UV");

  a_cor_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_COR) |-> !div_any_busy)
    else $error("CORDIC running while dividers busy");

  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result beat raised outside output state");

endmodule
